// File: design/wlfd_pkg.sv
`default_nettype none
package wlfd_pkg;

    localparam int CLS_W  = 3;
    localparam int SIZE_W = 12;
    localparam int ID_W   = 32;
    localparam int WIN_W  = 6;
    localparam int WAIT_W = 6;
    localparam int RUN_W  = 12;
    localparam int VIOL_W = 32;

    // dispatches per event and result store depth
    localparam int MAX_RESULTS = 32;
    localparam int RES_AW      = 5;
    localparam int RES_CW      = 6;

    localparam logic OP_ARRIVAL   = 1'b0;
    localparam logic OP_DEPARTURE = 1'b1;

    localparam logic CFG_WINDOW  = 1'b0;
    localparam logic CFG_SERVERS = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic [CLS_W-1:0]  cls;
    } entry_t;

    typedef struct packed {
        logic [VIOL_W-1:0] violations;
        logic [SIZE_W-1:0] free_servers;
        logic              out_of_order;
        entry_t            job;
    } result_t;

endpackage
`default_nettype wire

// File: design/window_largest_fit_job_dispatcher.sv
`default_nettype none
// Window largest-fit dispatcher: each input event (arrival or departure) is followed by up to
// 32 dispatches, each picking the largest fitting job among the leading window of the wait
// buffer. The block takes one event at a time. A dispatch starts the scan, reads then compares
// each searched entry (one comparator walks the buffer RAM), commits, and then moves each entry
// behind the dispatched job up by one. Results are held in a result RAM and sent once the event
// is finished, each held until the output takes it, so all results of one event carry the final
// class counts. tready is high only between events.
module window_largest_fit_job_dispatcher #(
    parameter int BUFFER_DEPTH = 32,
    parameter int CLASS_COUNT  = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // job_class, job_size, job_id
    input  wire logic         s_tuser,   // opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,   // started_class, started_id, started_size,
                                         // out_of_order, free_servers, violations,
                                         // overflow, class_waiting, class_running
    output logic              m_tuser,   // started
    output logic              m_tlast,   // last
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [11:0]  cfg_data
);
    import wlfd_pkg::*;

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int OW  = $clog2(BUFFER_DEPTH + 1);
    localparam int CW  = (OW > WIN_W) ? OW : WIN_W;
    localparam int CIW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_RD, S_CMP, S_DISP, S_SRD, S_SWR, S_ORD, S_OLD, S_OWAIT
    } state_t;

    state_t state_reg, state_next;

    logic [WIN_W-1:0]  win_reg, win_next;
    logic [SIZE_W-1:0] srv_reg, srv_next;
    logic [SIZE_W-1:0] free_reg, free_next;
    logic [VIOL_W-1:0] viol_reg, viol_next;
    logic [OW-1:0]     occ_reg, occ_next;
    logic [WAIT_W-1:0] wait_reg [CLASS_COUNT];
    logic [WAIT_W-1:0] wait_next [CLASS_COUNT];
    logic [RUN_W-1:0]  run_reg [CLASS_COUNT];
    logic [RUN_W-1:0]  run_next [CLASS_COUNT];
    logic [AW-1:0]     i_reg, i_next;
    logic [CW-1:0]     lim_reg, lim_next;
    logic [RES_CW-1:0] n_reg, n_next;
    logic [RES_CW-1:0] k_reg, k_next;
    logic [CLS_W-1:0]  cls_reg, cls_next;
    logic              ovf_reg, ovf_next;
    logic              mv_reg, mv_next;
    logic [111:0]      md_reg, md_next;
    logic              mu_reg, mu_next;
    logic              ml_reg, ml_next;

    // event input
    logic              in_acc;
    entry_t            in_ent;
    assign in_acc = s_tvalid && s_tready;
    assign in_ent = entry_t'{id: s_tdata[46:15], size: s_tdata[14:3], cls: s_tdata[2:0]};

    // buffer ram
    logic          b_we;
    logic [AW-1:0] b_waddr, b_raddr;
    entry_t        b_wdata, b_rdata;

    wlfd_buf #(.DEPTH(BUFFER_DEPTH), .AW(AW)) u_buf (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    // shared fit comparator
    logic          f_clear, f_en, f_found;
    logic [AW-1:0] f_idx;
    entry_t        f_best;

    wlfd_fit #(.AW(AW)) u_fit (
        .clk(clk), .rst_n(rst_n), .clear(f_clear), .en(f_en), .ent(b_rdata),
        .idx(i_reg), .free(free_reg), .found(f_found), .best_idx(f_idx), .best(f_best)
    );

    // result ram
    result_t           res_mem [MAX_RESULTS];
    result_t           res_rd_reg;
    logic              r_we;
    result_t           r_wdata;

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            res_mem[n_reg[RES_AW-1:0]] <= r_wdata;
        end
        res_rd_reg <= res_mem[k_reg[RES_AW-1:0]];
    end

    // one per-class port, address picked by phase
    logic [CLS_W-1:0] csel;
    logic [CIW-1:0]   cidx;
    logic             cok;
    always_comb
    begin
        case (state_reg)
            S_IDLE:  csel = in_ent.cls;
            S_DISP:  csel = f_best.cls;
            default: csel = cls_reg;
        endcase
    end
    assign cidx = CIW'(csel);
    assign cok  = 32'(csel) < CLASS_COUNT;

    logic [CW-1:0] occ_x, win_x;
    assign occ_x = CW'(occ_reg);
    assign win_x = CW'(win_reg);

    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        srv_next   = srv_reg;
        free_next  = free_reg;
        viol_next  = viol_reg;
        occ_next   = occ_reg;
        wait_next  = wait_reg;
        run_next   = run_reg;
        i_next     = i_reg;
        lim_next   = lim_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        cls_next   = cls_reg;
        ovf_next   = ovf_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        mu_next    = mu_reg;
        ml_next    = ml_reg;
        b_we       = 1'b0;
        b_waddr    = i_reg;
        b_wdata    = b_rdata;
        b_raddr    = i_reg;
        f_clear    = 1'b0;
        f_en       = 1'b0;
        r_we       = 1'b0;
        r_wdata    = result_t'{violations: viol_reg, free_servers: free_reg,
                               out_of_order: (f_idx != '0), job: f_best};

        if (cfg_we)
        begin
            if (cfg_index == CFG_WINDOW)
            begin
                win_next = cfg_data[WIN_W-1:0];
            end
            else
            begin
                srv_next  = cfg_data;
                free_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cls_next = in_ent.cls;
                    ovf_next = 1'b0;
                    n_next   = '0;
                    if (s_tuser == OP_ARRIVAL)
                    begin
                        if (occ_reg >= OW'(BUFFER_DEPTH))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            b_we     = 1'b1;
                            b_waddr  = AW'(occ_reg);
                            b_wdata  = in_ent;
                            occ_next = occ_reg + 1'b1;
                            if (cok && wait_reg[cidx] < {WAIT_W{1'b1}})
                            begin
                                wait_next[cidx] = wait_reg[cidx] + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (cok && run_reg[cidx] != '0)
                        begin
                            run_next[cidx] = run_reg[cidx] - 1'b1;
                        end
                        if (in_ent.size >= srv_reg || free_reg >= srv_reg - in_ent.size)
                        begin
                            free_next = srv_reg;
                        end
                        else
                        begin
                            free_next = free_reg + in_ent.size;
                        end
                    end
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (n_reg == RES_CW'(MAX_RESULTS) || occ_reg == '0 || free_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    i_next     = '0;
                    f_clear    = 1'b1;
                    lim_next   = (win_reg != '0 && win_x < occ_x) ? win_x : occ_x;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                f_en = 1'b1;
                if (CW'(i_reg) == lim_reg - 1'b1)
                begin
                    state_next = S_DISP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_DISP:
            begin
                if (!f_found)
                begin
                    k_next     = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    free_next = free_reg - f_best.size;
                    r_wdata.free_servers = free_reg - f_best.size;
                    if (f_idx != '0 && viol_reg != {VIOL_W{1'b1}})
                    begin
                        viol_next          = viol_reg + 1'b1;
                        r_wdata.violations = viol_reg + 1'b1;
                    end
                    if (cok)
                    begin
                        if (wait_reg[cidx] != '0)
                        begin
                            wait_next[cidx] = wait_reg[cidx] - 1'b1;
                        end
                        if (run_reg[cidx] != {RUN_W{1'b1}})
                        begin
                            run_next[cidx] = run_reg[cidx] + 1'b1;
                        end
                    end
                    r_we   = 1'b1;
                    n_next = n_reg + 1'b1;
                    i_next = f_idx;
                    if (OW'(f_idx) + 1'b1 < occ_reg)
                    begin
                        state_next = S_SRD;
                    end
                    else
                    begin
                        occ_next   = occ_reg - 1'b1;
                        state_next = S_CHK;
                    end
                end
            end
            S_SRD:
            begin
                b_raddr    = i_reg + 1'b1;
                state_next = S_SWR;
            end
            S_SWR:
            begin
                // move the later entry up over the gap
                b_we    = 1'b1;
                b_waddr = i_reg;
                i_next  = i_reg + 1'b1;
                if (OW'(i_reg) + 2'd2 < occ_reg)
                begin
                    state_next = S_SRD;
                end
                else
                begin
                    occ_next   = occ_reg - 1'b1;
                    state_next = S_CHK;
                end
            end
            S_ORD:
            begin
                state_next = S_OLD;
            end
            S_OLD:
            begin
                mv_next = 1'b1;
                if (n_reg == '0)
                begin
                    mu_next        = 1'b0;
                    md_next        = '0;
                    md_next[59:48] = free_reg;
                    md_next[91:60] = viol_reg;
                    ml_next        = 1'b1;
                end
                else
                begin
                    mu_next        = 1'b1;
                    md_next[2:0]   = res_rd_reg.job.cls;
                    md_next[34:3]  = res_rd_reg.job.id;
                    md_next[46:35] = res_rd_reg.job.size;
                    md_next[47]    = res_rd_reg.out_of_order;
                    md_next[59:48] = res_rd_reg.free_servers;
                    md_next[91:60] = res_rd_reg.violations;
                    ml_next        = (k_reg == n_reg - 1'b1);
                end
                md_next[92]      = ovf_reg;
                md_next[98:93]   = cok ? wait_reg[cidx] : '0;
                md_next[110:99]  = cok ? run_reg[cidx] : '0;
                md_next[111]     = 1'b0;
                state_next       = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (m_tready)
                begin
                    mv_next = 1'b0;
                    k_next  = k_reg + 1'b1;
                    if (ml_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            win_reg   <= '0;
            srv_reg   <= SIZE_W'(1);
            free_reg  <= SIZE_W'(1);
            viol_reg  <= '0;
            occ_reg   <= '0;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                wait_reg[c] <= '0;
                run_reg[c]  <= '0;
            end
            n_reg     <= '0;
            k_reg     <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            srv_reg   <= srv_next;
            free_reg  <= free_next;
            viol_reg  <= viol_next;
            occ_reg   <= occ_next;
            wait_reg  <= wait_next;
            run_reg   <= run_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        lim_reg <= lim_next;
        cls_reg <= cls_next;
        ovf_reg <= ovf_next;
        md_reg  <= md_next;
        mu_reg  <= mu_next;
        ml_reg  <= ml_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

    a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid) else $error("input ready while a result is pending");
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(BUFFER_DEPTH)) else $error("buffer occupancy beyond depth");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= srv_reg) else $error("free servers above server count");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not idle after final result");
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= RES_CW'(MAX_RESULTS)) else $error("too many results for one event");
endmodule
`default_nettype wire

// File: design/wlfd_buf.sv
`default_nettype none
module wlfd_buf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire wlfd_pkg::entry_t wdata,
    input  wire logic [AW-1:0]   raddr,
    output wlfd_pkg::entry_t     rdata
);
    import wlfd_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: design/wlfd_fit.sv
`default_nettype none
module wlfd_fit #(
    parameter int AW = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        clear,
    input  wire logic                        en,
    input  wire wlfd_pkg::entry_t            ent,
    input  wire logic [AW-1:0]               idx,
    input  wire logic [wlfd_pkg::SIZE_W-1:0] free,
    output logic                             found,
    output logic [AW-1:0]                    best_idx,
    output wlfd_pkg::entry_t                 best
);
    import wlfd_pkg::*;

    logic    found_reg;
    logic    found_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    entry_t  best_reg;
    entry_t  best_next;
    logic    take;

    // strictly larger keeps the earliest entry on a tie
    assign take = (ent.size <= free) && (!found_reg || (ent.size > best_reg.size));

    always_comb
    begin
        found_next = found_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (en && take)
        begin
            found_next = 1'b1;
            idx_next   = idx;
            best_next  = ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        best_reg <= best_next;
    end

    assign found    = found_reg;
    assign best_idx = idx_reg;
    assign best     = best_reg;
endmodule
`default_nettype wire
